// ----- hdl/dsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types and codes of the delta stream decoder.
// ----------------------------------------------------------------------------
package dsd_pkg;

  typedef enum logic [2:0] {
    KIND_HDR   = 3'd0,
    KIND_INSTR = 3'd1,
    KIND_NEW   = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ERR   = 3'd4,
    KIND_CLOSE = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_WSTART,
    PH_HDR,
    PH_SEL,
    PH_ILEN,
    PH_IOFF,
    PH_NEW
  } phase_t;

  localparam logic [1:0] ACT_SRC = 2'd0;
  localparam logic [1:0] ACT_TGT = 2'd1;
  localparam logic [1:0] ACT_NEW = 2'd2;
  localparam logic [1:0] ACT_BAD = 2'd3;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_MAGIC     = 4'd1;
  localparam logic [3:0] ERR_OVERFLOW  = 4'd2;
  localparam logic [3:0] ERR_BACKWARD  = 4'd3;
  localparam logic [3:0] ERR_SELECTOR  = 4'd4;
  localparam logic [3:0] ERR_ZERO_LEN  = 4'd5;
  localparam logic [3:0] ERR_TGT_OVF   = 4'd6;
  localparam logic [3:0] ERR_SRC_OVF   = 4'd7;
  localparam logic [3:0] ERR_TGT_AHEAD = 4'd8;
  localparam logic [3:0] ERR_NEW_OVF   = 4'd9;
  localparam logic [3:0] ERR_UNFILLED  = 4'd10;
  localparam logic [3:0] ERR_NEW_SHORT = 4'd11;
  localparam logic [3:0] ERR_TRUNC     = 4'd12;
  localparam logic [3:0] ERR_EARLY_END = 4'd13;

  localparam logic [7:0] MAGIC [4] = '{8'h53, 8'h56, 8'h4e, 8'h00};

  localparam int TDATA_W = 112;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  action;
    logic [31:0] length;
    logic [31:0] offset;
    logic [31:0] target_len;
    logic [7:0]  data_byte;
    logic [3:0]  error_code;
    logic        last;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

// ----- hdl/dsd_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_fifo
// Four-entry result queue: up to two writes, one read per cycle.
// ----------------------------------------------------------------------------
module dsd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  dsd_pkg::push_t push,
  input  logic           pop,
  output dsd_pkg::res_t  head,
  output logic           head_valid,
  output logic           room
);
  import dsd_pkg::*;

  res_t       mem_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign head_valid = (cnt_r != 3'd0);
  assign head       = mem_r[rd_r];
  assign room       = (cnt_r <= 3'd2);
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r + {1'b0, push.v0} + {1'b0, push.v1};
    rd_nxt  = rd_r + {1'b0, do_pop};
    cnt_nxt = cnt_r + {2'b0, push.v0} + {2'b0, push.v1} - {2'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) mem_r[wr_r] <= push.r0;
    if (push.v1) mem_r[wr_r + 2'd1] <= push.r1;
  end

endmodule

// ----- hdl/dsd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsd_core
// Input register and per-byte decode: magic, window header, instructions,
// new data and close; produces up to two results per byte.
// ----------------------------------------------------------------------------
module dsd_core #(
  parameter int VALUE_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_close,
  input  logic           strict_close,
  input  logic           room,
  output dsd_pkg::push_t push
);
  import dsd_pkg::*;

  localparam int W = VALUE_BITS;

  typedef struct packed {
    logic [3:0]   err;
    logic [W-1:0] off;
    logic [W-1:0] tp;
    logic [W-1:0] np;
  } fin_t;

  function automatic logic [31:0] to32(input logic [W-1:0] v);
    logic [W+31:0] t;
    t = {32'b0, v};
    return t[31:0];
  endfunction

  function automatic res_t mk(input kind_t k, input logic [1:0] a, input logic [W-1:0] l,
                              input logic [W-1:0] o, input logic [W-1:0] tl,
                              input logic [7:0] d, input logic [3:0] e);
    res_t r;
    r.kind = k; r.action = a; r.length = to32(l); r.offset = to32(o);
    r.target_len = to32(tl); r.data_byte = d; r.error_code = e; r.last = 1'b0;
    return r;
  endfunction

  function automatic fin_t fin(input logic [1:0] act, input logic [W-1:0] len,
                               input logic [W-1:0] off, input logic [W-1:0] tvl,
                               input logic [W-1:0] tp, input logic [W-1:0] svl,
                               input logic [W-1:0] ndl, input logic [W-1:0] np);
    fin_t f;
    f.err = ERR_NONE; f.off = off; f.tp = tp + len; f.np = np;
    if (len == '0) f.err = ERR_ZERO_LEN;
    else if (len > tvl - tp) f.err = ERR_TGT_OVF;
    else if (act == ACT_SRC) begin
      if (off > svl || len > svl - off) f.err = ERR_SRC_OVF;
    end else if (act == ACT_TGT) begin
      if (off >= tp) f.err = ERR_TGT_AHEAD;
    end else begin
      if (len > ndl - np) f.err = ERR_NEW_OVF;
      f.off = np;
      f.np  = np + len;
    end
    return f;
  endfunction

  // input register
  logic       s_v_r;
  logic [7:0] s_b_r;
  logic       s_c_r;
  logic       fire;

  assign fire     = s_v_r && room;
  assign in_ready = !s_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) s_v_r <= 1'b0;
    else if (in_ready) s_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_b_r <= in_byte;
      s_c_r <= in_close;
    end
  end

  // decoder state
  logic [2:0]   magic_r, magic_nxt;
  phase_t       phase_r, phase_nxt;
  logic [W-1:0] acc_r, acc_nxt;
  logic [2:0]   fi_r, fi_nxt;
  logic [W-1:0] svo_r, svo_nxt, svl_r, svl_nxt, tvl_r, tvl_nxt;
  logic [W-1:0] insr_r, insr_nxt, ndl_r, ndl_nxt, newr_r, newr_nxt;
  logic [W-1:0] tp_r, tp_nxt, np_r, np_nxt;
  logic [1:0]   act_r, act_nxt;
  logic [W-1:0] clen_r, clen_nxt, pso_r, pso_nxt, psl_r, psl_nxt;
  logic         failed_r, failed_nxt, closed_r, closed_nxt;

  res_t         em [2];
  logic [1:0]   cnt;
  logic         do_end, do_wd, complete;
  logic [W:0]   sum, psum;
  logic [W-1:0] acc_new, off_v;
  fin_t         f;

  always_comb begin
    magic_nxt = magic_r; phase_nxt = phase_r; acc_nxt = acc_r; fi_nxt = fi_r;
    svo_nxt = svo_r; svl_nxt = svl_r; tvl_nxt = tvl_r; insr_nxt = insr_r;
    ndl_nxt = ndl_r; newr_nxt = newr_r; tp_nxt = tp_r; np_nxt = np_r;
    act_nxt = act_r; clen_nxt = clen_r; pso_nxt = pso_r; psl_nxt = psl_r;
    failed_nxt = failed_r; closed_nxt = closed_r;
    em[0] = '0; em[1] = '0; cnt = 2'd0;
    do_end = 1'b0; do_wd = 1'b0; complete = 1'b0;
    sum = '0; psum = '0; acc_new = '0; off_v = '0; f = '0;

    if (fire && !failed_r && !closed_r) begin
      if (s_c_r) begin
        if (strict_close && (magic_r < 3'd4 || phase_r != PH_WSTART)) begin
          failed_nxt = 1'b1;
          em[0] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_EARLY_END);
        end else begin
          closed_nxt = 1'b1;
          em[0] = mk(KIND_CLOSE, '0, '0, '0, '0, '0, ERR_NONE);
        end
        cnt = 2'd1;
      end else if (magic_r < 3'd4) begin
        if (s_b_r != MAGIC[magic_r[1:0]]) begin
          failed_nxt = 1'b1;
          em[0] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_MAGIC);
          cnt = 2'd1;
        end else magic_nxt = magic_r + 3'd1;
      end else if (phase_r == PH_WSTART || phase_r == PH_HDR) begin
        if (phase_r == PH_WSTART) begin
          fi_nxt = '0;
          acc_nxt = '0;
        end
        phase_nxt = PH_HDR;
        acc_new = {acc_nxt[W-8:0], s_b_r[6:0]};
        if (acc_nxt[W-1:W-7] != '0) begin
          failed_nxt = 1'b1;
          em[0] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_OVERFLOW);
          cnt = 2'd1;
        end else if (s_b_r[7]) begin
          acc_nxt = acc_new;
        end else begin
          case (fi_nxt)
            3'd0:    svo_nxt  = acc_new;
            3'd1:    svl_nxt  = acc_new;
            3'd2:    tvl_nxt  = acc_new;
            3'd3:    insr_nxt = acc_new;
            default: ndl_nxt  = acc_new;
          endcase
          acc_nxt = '0;
          if (fi_nxt >= 3'd4) begin
            fi_nxt = '0;
            sum  = {1'b0, svo_nxt} + {1'b0, svl_nxt};
            psum = {1'b0, pso_r} + {1'b0, psl_r};
            if (sum[W]) begin
              failed_nxt = 1'b1;
              em[0] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_OVERFLOW);
              cnt = 2'd1;
            end else if (svl_nxt != '0 && (svo_nxt < pso_r || sum < psum)) begin
              failed_nxt = 1'b1;
              em[0] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_BACKWARD);
              cnt = 2'd1;
            end else begin
              pso_nxt = svo_nxt; psl_nxt = svl_nxt;
              tp_nxt = '0; np_nxt = '0;
              em[0] = mk(KIND_HDR, '0, svl_nxt, svo_nxt, tvl_nxt, '0, ERR_NONE);
              cnt = 2'd1;
              if (insr_nxt == '0) do_end = 1'b1;
              else phase_nxt = PH_SEL;
            end
          end else fi_nxt = fi_nxt + 3'd1;
        end
      end else if (phase_r == PH_NEW) begin
        em[0] = mk(KIND_NEW, '0, '0, '0, '0, s_b_r, ERR_NONE);
        cnt = 2'd1;
        newr_nxt = newr_r - W'(1);
        if (newr_nxt == '0) do_wd = 1'b1;
      end else begin
        insr_nxt = insr_r - W'(1);
        if (phase_r == PH_SEL) begin
          if (s_b_r[7:6] == ACT_BAD) begin
            failed_nxt = 1'b1;
            em[0] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_SELECTOR);
            cnt = 2'd1;
          end else begin
            act_nxt  = s_b_r[7:6];
            clen_nxt = W'(s_b_r[5:0]);
            acc_nxt  = '0;
            if (s_b_r[5:0] == 6'd0) phase_nxt = PH_ILEN;
            else if (s_b_r[7:6] == ACT_NEW) complete = 1'b1;
            else phase_nxt = PH_IOFF;
          end
        end else begin
          acc_new = {acc_r[W-8:0], s_b_r[6:0]};
          if (acc_r[W-1:W-7] != '0) begin
            failed_nxt = 1'b1;
            em[0] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_OVERFLOW);
            cnt = 2'd1;
          end else if (s_b_r[7]) begin
            acc_nxt = acc_new;
          end else begin
            acc_nxt = '0;
            if (phase_r == PH_ILEN) begin
              clen_nxt = acc_new;
              if (act_r == ACT_NEW) complete = 1'b1;
              else phase_nxt = PH_IOFF;
            end else begin
              off_v = acc_new;
              complete = 1'b1;
            end
          end
        end
        // complete here means an instruction is ready to be checked
        if (complete) begin
          f = fin(act_nxt, clen_nxt, off_v, tvl_r, tp_r, svl_r, ndl_r, np_r);
          if (f.err != ERR_NONE) begin
            failed_nxt = 1'b1;
            em[0] = mk(KIND_ERR, '0, '0, '0, '0, '0, f.err);
            cnt = 2'd1;
          end else begin
            tp_nxt = f.tp; np_nxt = f.np;
            em[0] = mk(KIND_INSTR, act_nxt, clen_nxt, f.off, '0, '0, ERR_NONE);
            cnt = 2'd1;
            phase_nxt = PH_SEL;
          end
        end
        if (!failed_nxt && insr_nxt == '0) begin
          if (complete) do_end = 1'b1;
          else begin
            failed_nxt = 1'b1;
            em[cnt[0]] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_TRUNC);
            cnt = cnt + 2'd1;
          end
        end
      end

      // end of the instruction section
      if (do_end) begin
        if (tp_nxt != tvl_nxt) begin
          failed_nxt = 1'b1;
          em[cnt[0]] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_UNFILLED);
          cnt = cnt + 2'd1;
        end else if (np_nxt != ndl_nxt) begin
          failed_nxt = 1'b1;
          em[cnt[0]] = mk(KIND_ERR, '0, '0, '0, '0, '0, ERR_NEW_SHORT);
          cnt = cnt + 2'd1;
        end else begin
          newr_nxt = ndl_nxt;
          if (ndl_nxt == '0) do_wd = 1'b1;
          else phase_nxt = PH_NEW;
        end
      end
      if (do_wd) begin
        em[cnt[0]] = mk(KIND_DONE, '0, '0, '0, '0, '0, ERR_NONE);
        cnt = cnt + 2'd1;
        phase_nxt = PH_WSTART;
        fi_nxt = '0;
        acc_nxt = '0;
      end
      if (cnt == 2'd2) em[1].last = 1'b1;
      else em[0].last = 1'b1;
    end

    push.v0 = (cnt != 2'd0);
    push.v1 = (cnt == 2'd2);
    push.r0 = em[0];
    push.r1 = em[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0; phase_r <= PH_WSTART; acc_r <= '0; fi_r <= '0;
      svo_r <= '0; svl_r <= '0; tvl_r <= '0; insr_r <= '0; ndl_r <= '0;
      newr_r <= '0; tp_r <= '0; np_r <= '0; act_r <= '0; clen_r <= '0;
      pso_r <= '0; psl_r <= '0; failed_r <= 1'b0; closed_r <= 1'b0;
    end else begin
      magic_r <= magic_nxt; phase_r <= phase_nxt; acc_r <= acc_nxt; fi_r <= fi_nxt;
      svo_r <= svo_nxt; svl_r <= svl_nxt; tvl_r <= tvl_nxt; insr_r <= insr_nxt;
      ndl_r <= ndl_nxt; newr_r <= newr_nxt; tp_r <= tp_nxt; np_r <= np_nxt;
      act_r <= act_nxt; clen_r <= clen_nxt; pso_r <= pso_nxt; psl_r <= psl_nxt;
      failed_r <= failed_nxt; closed_r <= closed_nxt;
    end
  end

endmodule

// ----- hdl/delta_stream_decoder.sv -----
`timescale 1ns / 1ps
// An accepted byte is held in the input register, decoded from it into the
// result queue once the queue has room, and presented from the queue head.
// Throughput: one byte per cycle; a byte giving two results briefly takes
// the result queue's spare slot; input is held off while three or more wait.
// Reset: synchronous, active low; clears decoder state and queue, sets strict_close to 1.
// ----------------------------------------------------------------------------
// delta_stream_decoder
// Byte-serial version-0 delta stream decoder with stream in and result out.
// ----------------------------------------------------------------------------
module delta_stream_decoder #(
  parameter int VALUE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] byte_in
  input  logic                        in_tuser,   // close_stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] action, [33:2] length, [65:34] offset, [97:66] target_len,
  // [105:98] data_byte, [109:106] error_code, [111:110] zero
  output logic [dsd_pkg::TDATA_W-1:0] out_tdata,
  output logic [2:0]                  out_tuser,  // kind
  output logic                        out_tlast,  // last
  input  logic                        cfg_we,
  input  logic                        cfg_wdata   // strict_close
);
  import dsd_pkg::*;

  logic  strict_r;
  logic  room;
  push_t push;
  res_t  head;

  always_ff @(posedge clk) begin
    if (!rst_n) strict_r <= 1'b1;
    else if (cfg_we) strict_r <= cfg_wdata;
  end

  dsd_core #(.VALUE_BITS(VALUE_BITS)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_byte      (in_tdata),
    .in_close     (in_tuser),
    .strict_close (strict_r),
    .room         (room),
    .push         (push)
  );

  dsd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (out_tready),
    .head       (head),
    .head_valid (out_tvalid),
    .room       (room)
  );

  assign out_tdata = {2'b00, head.error_code, head.data_byte, head.target_len,
                      head.offset, head.length, head.action};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ----- test/delta_stream_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_stream_decoder_tb
// One delta stream per run: magic, directed windows, then random well-formed
// windows with random content, ending in a close, in some runs after a corrupted tail, then random trailing bytes.
// strict_close is rewritten between phases. A behavioural decoder predicts
// every result; results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module delta_stream_decoder_tb;
  import dsd_pkg::*;

  localparam logic [63:0] VAL_MASK = 64'hffff_ffff;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [2:0] out_tuser;
  logic out_tlast;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  always #1 clk = ~clk;

  delta_stream_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  logic [8:0] stream_bytes[$];   // {close, byte}
  res_t decoded_results[$];
  res_t step_results[$];
  int errors = 0;
  int cycle_n = 0;
  int stall_n = 0;

  // ---- behavioural decoder ----
  logic m_strict;
  int m_magic_n;
  phase_t m_phase;
  int m_field;
  logic [1:0] m_action;
  logic [63:0] m_acc, m_soff, m_slen, m_tlen, m_ins_left, m_new_len, m_new_left;
  logic [63:0] m_tpos, m_new_pos, m_len, m_prev_off, m_prev_len;
  logic m_failed, m_closed;

  task put_result(input kind_t k, input logic [1:0] a, input logic [63:0] len,
                  input logic [63:0] off, input logic [63:0] tl, input logic [7:0] db,
                  input logic [3:0] ec);
    res_t r;
    r.kind = k; r.action = a; r.length = len[31:0]; r.offset = off[31:0];
    r.target_len = tl[31:0]; r.data_byte = db; r.error_code = ec; r.last = 1'b0;
    step_results.push_back(r);
  endtask

  task flag_error(input logic [3:0] ec);
    m_failed = 1'b1;
    put_result(KIND_ERR, ACT_SRC, 0, 0, 0, 0, ec);
  endtask

  // -1 overflow, 0 continues, 1 complete
  function int accum_digit(input logic [7:0] b);
    if (m_acc > (VAL_MASK >> 7)) return -1;
    m_acc = (m_acc << 7) | {57'd0, b[6:0]};
    return b[7] ? 0 : 1;
  endfunction

  task close_window;
    put_result(KIND_DONE, ACT_SRC, 0, 0, 0, 0, ERR_NONE);
    m_phase = PH_WSTART; m_field = 0; m_acc = 0;
  endtask

  task close_instructions;
    if (m_tpos != m_tlen) flag_error(ERR_UNFILLED);
    else if (m_new_pos != m_new_len) flag_error(ERR_NEW_SHORT);
    else begin
      m_new_left = m_new_len;
      if (m_new_left == 0) close_window();
      else m_phase = PH_NEW;
    end
  endtask

  task complete_instr(input logic [63:0] off_in, output bit ok);
    logic [63:0] off;
    off = off_in;
    ok = 1'b0;
    if (m_len == 0) flag_error(ERR_ZERO_LEN);
    else if (m_len > m_tlen - m_tpos) flag_error(ERR_TGT_OVF);
    else if (m_action == ACT_SRC && (off > m_slen || m_len > m_slen - off))
      flag_error(ERR_SRC_OVF);
    else if (m_action == ACT_TGT && off >= m_tpos) flag_error(ERR_TGT_AHEAD);
    else if (m_action == ACT_NEW && m_len > m_new_len - m_new_pos) flag_error(ERR_NEW_OVF);
    else begin
      if (m_action == ACT_NEW) begin
        off = m_new_pos;
        m_new_pos += m_len;
      end
      m_tpos += m_len;
      put_result(KIND_INSTR, m_action, m_len, off, 0, 0, ERR_NONE);
      m_phase = PH_SEL;
      ok = 1'b1;
    end
  endtask

  task header_digit(input logic [7:0] b);
    int r;
    r = accum_digit(b);
    if (r < 0) flag_error(ERR_OVERFLOW);
    else if (r == 1) begin
      case (m_field)
        0: m_soff = m_acc;
        1: m_slen = m_acc;
        2: m_tlen = m_acc;
        3: m_ins_left = m_acc;
        default: m_new_len = m_acc;
      endcase
      m_acc = 0;
      if (m_field < 4) m_field++;
      else begin
        m_field = 0;
        if (m_soff > VAL_MASK - m_slen) flag_error(ERR_OVERFLOW);
        else if (m_slen > 0 && (m_soff < m_prev_off ||
                 m_soff + m_slen < m_prev_off + m_prev_len)) flag_error(ERR_BACKWARD);
        else begin
          m_prev_off = m_soff; m_prev_len = m_slen;
          m_tpos = 0; m_new_pos = 0;
          put_result(KIND_HDR, ACT_SRC, m_slen, m_soff, m_tlen, 0, ERR_NONE);
          if (m_ins_left == 0) close_instructions();
          else m_phase = PH_SEL;
        end
      end
    end
  endtask

  task instr_digit(input logic [7:0] b);
    bit done_ok, ok;
    int r;
    done_ok = 1'b0;
    ok = 1'b1;
    m_ins_left--;
    if (m_phase == PH_SEL) begin
      if (b[7:6] == ACT_BAD) begin flag_error(ERR_SELECTOR); ok = 1'b0; end
      else begin
        m_action = b[7:6];
        m_len = {58'd0, b[5:0]};
        m_acc = 0;
        if (m_len == 0) m_phase = PH_ILEN;
        else if (m_action == ACT_NEW) begin complete_instr(0, ok); done_ok = ok; end
        else m_phase = PH_IOFF;
      end
    end else begin
      r = accum_digit(b);
      if (r < 0) begin flag_error(ERR_OVERFLOW); ok = 1'b0; end
      else if (r == 1) begin
        if (m_phase == PH_ILEN) begin
          m_len = m_acc; m_acc = 0;
          if (m_action == ACT_NEW) begin complete_instr(0, ok); done_ok = ok; end
          else m_phase = PH_IOFF;
        end else begin
          complete_instr(m_acc, ok);
          m_acc = 0;
          done_ok = ok;
        end
      end
    end
    if (ok && m_ins_left == 0) begin
      if (done_ok) close_instructions();
      else flag_error(ERR_TRUNC);
    end
  endtask

  task predict_transaction(input logic [7:0] b, input logic cl);
    res_t r;
    step_results.delete();
    if (!(m_failed || m_closed)) begin
      if (cl) begin
        if (m_strict && (m_magic_n < 4 || m_phase != PH_WSTART)) flag_error(ERR_EARLY_END);
        else begin
          m_closed = 1'b1;
          put_result(KIND_CLOSE, ACT_SRC, 0, 0, 0, 0, ERR_NONE);
        end
      end else if (m_magic_n < 4) begin
        if (b != MAGIC[m_magic_n]) flag_error(ERR_MAGIC);
        else m_magic_n++;
      end else if (m_phase == PH_WSTART || m_phase == PH_HDR) begin
        if (m_phase == PH_WSTART) begin m_phase = PH_HDR; m_field = 0; m_acc = 0; end
        header_digit(b);
      end else if (m_phase == PH_NEW) begin
        put_result(KIND_NEW, ACT_SRC, 0, 0, 0, b, ERR_NONE);
        m_new_left--;
        if (m_new_left == 0) close_window();
      end else instr_digit(b);
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) begin
      r = step_results[i];
      decoded_results.push_back(r);
    end
  endtask

  // ---- stimulus generation ----
  logic [63:0] g_prev_off = 0, g_prev_len = 0;

  task automatic put_varint(input logic [63:0] v, ref logic [7:0] q[$]);
    int n;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    for (int i = n - 1; i >= 0; i--)
      q.push_back({(i > 0), 7'(v >> (7 * i))});
  endtask

  task automatic push_bytes(ref logic [7:0] q[$]);
    foreach (q[i]) stream_bytes.push_back({1'b0, q[i]});
  endtask

  task automatic build_window(input int max_len, input int max_src);
    logic [63:0] soff, slen, tpos, nlen, need, off;
    logic [7:0] ib[$], hq[$];
    int n, act, len;
    soff = g_prev_off + (($urandom % 4 == 0) ? $urandom_range(0, 65535) : 0);
    need = (g_prev_off + g_prev_len > soff) ? g_prev_off + g_prev_len - soff : 0;
    slen = need + $urandom_range(0, max_src);
    if ($urandom % 6 == 0) slen = 0;
    n = $urandom_range(0, 5);
    tpos = 0; nlen = 0;
    for (int i = 0; i < n; i++) begin
      act = $urandom_range(0, 2);
      len = ($urandom % 10 == 0) ? $urandom_range(64, 100) : $urandom_range(1, max_len);
      if (act == ACT_SRC && slen < len) act = ACT_NEW;
      if (act == ACT_TGT && tpos == 0) act = ACT_NEW;
      if (len < 64 && $urandom % 4 != 0) ib.push_back({2'(act), 6'(len)});
      else begin
        ib.push_back({2'(act), 6'd0});
        put_varint(len, ib);
      end
      if (act == ACT_SRC) begin
        off = $urandom_range(0, 32'(slen - len));
        put_varint(off, ib);
      end else if (act == ACT_TGT) begin
        off = $urandom_range(0, 32'(tpos - 1));
        put_varint(off, ib);
      end else nlen += len;
      tpos += len;
    end
    put_varint(soff, hq); put_varint(slen, hq); put_varint(tpos, hq);
    put_varint(ib.size(), hq); put_varint(nlen, hq);
    push_bytes(hq);
    push_bytes(ib);
    for (int i = 0; i < nlen; i++) stream_bytes.push_back({1'b0, 8'($urandom)});
    g_prev_off = soff; g_prev_len = slen;
  endtask

  task write_strict(input logic v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    m_strict = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task drain;
    wait (stream_bytes.size() == 0 && !in_tvalid && decoded_results.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // ---- driver ----
  function bit hold_off;
    return !(cycle_n > 800 && cycle_n < 1400) && $urandom_range(0, 99) < 22;
  endfunction

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off();
      if (in_tvalid && in_tready) predict_transaction(in_tdata, in_tuser);
      if (!in_tvalid || in_tready) begin
        if (stream_bytes.size() > 0 && !hold_off()) begin
          {in_tuser, in_tdata} <= stream_bytes.pop_front();
          in_tvalid <= 1'b1;
        end else in_tvalid <= 1'b0;
      end
    end
  end

  // ---- monitor ----
  task report(input string what, input logic [31:0] want, input logic [31:0] got);
    if (errors < 40) $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_results.size() == 0) report("unexpected transaction", 0, out_tuser);
      else begin
        e = decoded_results.pop_front();
        if (out_tuser != e.kind) report("kind", e.kind, out_tuser);
        if (out_tdata[1:0] != e.action) report("action", e.action, out_tdata[1:0]);
        if (out_tdata[33:2] != e.length) report("length", e.length, out_tdata[33:2]);
        if (out_tdata[65:34] != e.offset) report("offset", e.offset, out_tdata[65:34]);
        if (out_tdata[97:66] != e.target_len) report("target_len", e.target_len, out_tdata[97:66]);
        if (out_tdata[105:98] != e.data_byte) report("data_byte", e.data_byte, out_tdata[105:98]);
        if (out_tdata[109:106] != e.error_code)
          report("error_code", e.error_code, out_tdata[109:106]);
        if (out_tlast != e.last) report("last", e.last, out_tlast);
      end
    end
  end

  // ---- watchdog ----
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) stall_n <= 0;
    else stall_n <= stall_n + 1;
    if (stall_n >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- sequence ----
  initial begin
    logic [7:0] q[$];
    int tail;
    m_strict = 1'b1; m_magic_n = 0; m_phase = PH_WSTART; m_field = 0; m_action = ACT_SRC;
    m_acc = 0; m_soff = 0; m_slen = 0; m_tlen = 0; m_ins_left = 0; m_new_len = 0;
    m_new_left = 0; m_tpos = 0; m_new_pos = 0; m_len = 0; m_prev_off = 0; m_prev_len = 0;
    m_failed = 1'b0; m_closed = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_strict(1'b0);

    // magic, an empty window, one window with all three actions inline
    for (int i = 0; i < 4; i++) stream_bytes.push_back({1'b0, MAGIC[i]});
    for (int i = 0; i < 5; i++) stream_bytes.push_back(9'h000);
    q = '{8'd0, 8'd8, 8'd7, 8'd5, 8'd3, 8'h83, 8'h02, 8'h01, 8'h42, 8'h00,
          8'h00, 8'hff, 8'ha5};
    push_bytes(q);
    g_prev_off = 0; g_prev_len = 8;
    build_window(8, 16);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      while (stream_bytes.size() < 450) build_window(8, (ph == 1) ? (1 << 20) : 64);
      drain();
      write_strict(ph[0] ? 1'b0 : 1'b1);
    end
    write_strict(1'($urandom));

    // end of stream: clean close, close mid-header, garbage tail, wide integer
    q.delete();
    case ($urandom_range(0, 3))
      0: ;
      1: begin put_varint(g_prev_off, q); put_varint(7, q); end
      2: for (int i = 0; i < 24; i++) q.push_back(8'($urandom));
      default: for (int i = 0; i < 6; i++) q.push_back(8'hff);
    endcase
    push_bytes(q);
    stream_bytes.push_back({1'b1, 8'($urandom)});
    tail = $urandom_range(1, 4);
    for (int i = 0; i < tail; i++) stream_bytes.push_back({1'($urandom), 8'($urandom)});
    wait (stream_bytes.size() == 0 && !in_tvalid && decoded_results.size() == 0);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- delta_stream_decoder.f -----
hdl/dsd_pkg.sv
hdl/dsd_fifo.sv
hdl/dsd_core.sv
hdl/delta_stream_decoder.sv
test/delta_stream_decoder_tb.sv
